// ----- rtl/xor_packet_deframer_responder_assert.svh -----
// Assertion macros shared by the deframer/responder modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef XOR_PACKET_DEFRAMER_RESPONDER_ASSERT_SVH
`define XOR_PACKET_DEFRAMER_RESPONDER_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define XPDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks an implication at every rising clock edge outside of reset.
`define XPDR_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/xpdr_pkg.sv -----
// Package of the XOR packet deframer/responder: command codes, packet
// selectors, configuration indexes and the command descriptor type.
package xpdr_pkg;

  localparam logic [7:0] ACK_BIT     = 8'h80;
  localparam logic [7:0] CMD_STARTUP = 8'h04;
  localparam logic [7:0] CMD_VERSION = 8'h09;
  localparam logic [7:0] CMD_NUMBER  = 8'h0B;
  localparam logic [7:0] SUB_GET     = 8'h01;
  localparam logic [7:0] SUB_SET     = 8'h02;
  localparam logic [7:0] VERSION_TAG = 8'h76;

  // One bit per response packet, in the order the packets go out.
  localparam logic [3:0] PKT_STARTUP = 4'b0001;
  localparam logic [3:0] PKT_VERSION = 4'b0010;
  localparam logic [3:0] PKT_NUMBER  = 4'b0100;
  localparam logic [3:0] PKT_ACK     = 4'b1000;

  // Byte positions inside a five-byte packet.
  localparam logic [2:0] POS_CHECKSUM = 3'd4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAJOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_NUM   = 2'd2;

  typedef struct packed {
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] initial_number;
  } cfg_t;

  // Everything the back part needs to send the responses of one packet.
  typedef struct packed {
    logic [3:0]  pkt_mask;
    logic [7:0]  ack_cmd;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [15:0] number;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
  } cmd_t;

endpackage

// ----- rtl/xor_packet_deframer_responder.sv -----
// Top level of the XOR-checksummed five-byte packet deframer/responder.
// Holds the configuration registers; uses xpdr_front, xpdr_cmd_fifo, xpdr_back.
//
//   channel   direction  handshake            data
//   rx        in         push / full          rx_byte_i
//   tx        out        empty / pop          tx_byte_o, last_byte_o
//   config    in         cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// A received word is taken while push is high and full is low; full is high only while the
// descriptor queue (CmdDepth entries) is full.
// Responses leave one word per cycle from an output register while pop is held high;
// a packet enters the queue with its checksum word and is answered from the queue head.
// A stalled tx side stops only the back part until the queue fills.
// Reset is asynchronous, active low, and needs no clearing pass.
module xor_packet_deframer_responder import xpdr_pkg::*; #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            rx_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            tx_byte_o,
  output logic                  last_byte_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd, head_cmd;
  logic front_push, q_empty, q_pop, accept;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERSION_MAJOR: cfg_d.version_major  = cfg_wdata_i[7:0];
        CFG_VERSION_MINOR: cfg_d.version_minor  = cfg_wdata_i[7:0];
        CFG_INITIAL_NUM:   cfg_d.initial_number = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version_major  <= 8'd1;
      cfg_q.version_minor  <= 8'd0;
      cfg_q.initial_number <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = push && !full;

  xpdr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .push_o    (front_push),
    .cmd_o     (front_cmd)
  );

  xpdr_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_cmd)
  );

  xpdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ----- rtl/xpdr_front.sv -----
// Front part: frames received bytes into checksummed packets, decodes the
// command and writes a response descriptor. Depends on xpdr_pkg.
`include "xor_packet_deframer_responder_assert.svh"

module xpdr_front import xpdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0]  win_q [4];
  logic [7:0]  win_d [4];
  logic [2:0]  pos_q, pos_d;
  logic [15:0] num_q, num_d;
  logic        num_set_q, num_set_d;

  logic        match;
  logic [7:0]  base_cmd;
  logic [3:0]  mask;
  logic        ok;
  logic        do_set;

  assign match    = (pos_q == POS_CHECKSUM) &&
                    ((win_q[0] ^ win_q[1] ^ win_q[2] ^ win_q[3]) == rx_byte_i);
  assign base_cmd = win_q[0] & ~ACK_BIT;

  always_comb begin
    mask   = '0;
    ok     = 1'b0;
    do_set = 1'b0;
    unique case (base_cmd)
      CMD_STARTUP: begin
        mask = PKT_STARTUP | PKT_VERSION | PKT_NUMBER;
        ok   = 1'b1;
      end
      CMD_VERSION: begin
        mask = PKT_VERSION;
        ok   = 1'b1;
      end
      CMD_NUMBER: begin
        if (win_q[1] == SUB_GET) begin
          mask = PKT_NUMBER;
          ok   = 1'b1;
        end else if (win_q[1] == SUB_SET) begin
          do_set = 1'b1;
          ok     = 1'b1;
        end
      end
      default: ;
    endcase
    if ((win_q[0] & ACK_BIT) != '0) begin
      mask = mask | PKT_ACK;
    end
  end

  always_comb begin
    win_d     = win_q;
    pos_d     = pos_q;
    num_d     = num_q;
    num_set_d = num_set_q;
    if (accept_i) begin
      if (pos_q < POS_CHECKSUM) begin
        win_d[pos_q[1:0]] = rx_byte_i;
        pos_d             = pos_q + 3'd1;
      end else if (pos_q == POS_CHECKSUM) begin
        if (match) begin
          pos_d = '0;
          if (do_set) begin
            num_d     = {win_q[3], win_q[2]};
            num_set_d = 1'b1;
          end
        end else begin
          // Bad checksum: slide the window and try again on the next byte.
          win_d[0] = win_q[1];
          win_d[1] = win_q[2];
          win_d[2] = win_q[3];
          win_d[3] = rx_byte_i;
        end
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '{default: '0};
      pos_q     <= '0;
      num_q     <= '0;
      num_set_q <= 1'b0;
    end else begin
      win_q     <= win_d;
      pos_q     <= pos_d;
      num_q     <= num_d;
      num_set_q <= num_set_d;
    end
  end

  // The number is resolved here so that later set commands do not reach
  // responses still waiting in the queue.
  assign push_o               = accept_i && match && (mask != '0);
  assign cmd_o.pkt_mask       = mask;
  assign cmd_o.ack_cmd        = ok ? (win_q[0] | ACK_BIT) : (win_q[0] & ~ACK_BIT);
  assign cmd_o.p1             = win_q[1];
  assign cmd_o.p2             = win_q[2];
  assign cmd_o.p3             = win_q[3];
  assign cmd_o.number         = num_set_q ? num_q : cfg_i.initial_number;
  assign cmd_o.version_major  = cfg_i.version_major;
  assign cmd_o.version_minor  = cfg_i.version_minor;

  `XPDR_ASSERT(a_pos_range, pos_q <= POS_CHECKSUM, "front: byte position out of range")

endmodule

// ----- rtl/xpdr_cmd_fifo.sv -----
// Short queue of response descriptors between the front and back parts.
// Depends on xpdr_pkg for the descriptor type.
`include "xor_packet_deframer_responder_assert.svh"

module xpdr_cmd_fifo import xpdr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `XPDR_ASSERT(a_cnt_range, cnt_q <= CntW'(Depth), "fifo: count above depth")
  `XPDR_ASSERT(a_no_overflow, !(push_i && full_o), "fifo: push while full")

endmodule

// ----- rtl/xpdr_back.sv -----
// Back part: walks the packets of the descriptor at the queue head and
// sends one byte a cycle while pop keeps the output register free. Depends on xpdr_pkg.
`include "xor_packet_deframer_responder_assert.svh"

module xpdr_back import xpdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  logic       busy_q, busy_d;
  logic [3:0] rem_q, rem_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] tx_q;
  logic       last_q;

  logic [3:0] eff_mask, cur, next_rem;
  logic [7:0] b0, b1, b2, b3, byte_sel;
  logic       load, emit, end_pkt, last_word;

  // While a descriptor is in progress the remaining packets are held in
  // rem_q; a fresh descriptor starts from its own mask.
  assign eff_mask = busy_q ? rem_q : cmd_i.pkt_mask;
  assign cur      = eff_mask & (~eff_mask + 4'd1);
  assign next_rem = eff_mask & ~cur;

  always_comb begin
    unique case (cur)
      PKT_STARTUP: begin
        b0 = CMD_STARTUP; b1 = '0; b2 = '0; b3 = '0;
      end
      PKT_VERSION: begin
        b0 = CMD_VERSION; b1 = VERSION_TAG;
        b2 = cmd_i.version_major; b3 = cmd_i.version_minor;
      end
      PKT_NUMBER: begin
        b0 = CMD_NUMBER; b1 = SUB_GET;
        b2 = cmd_i.number[7:0]; b3 = cmd_i.number[15:8];
      end
      PKT_ACK: begin
        b0 = cmd_i.ack_cmd; b1 = cmd_i.p1; b2 = cmd_i.p2; b3 = cmd_i.p3;
      end
      default: begin
        b0 = '0; b1 = '0; b2 = '0; b3 = '0;
      end
    endcase
  end

  always_comb begin
    case (idx_q)
      3'd0:    byte_sel = b0;
      3'd1:    byte_sel = b1;
      3'd2:    byte_sel = b2;
      3'd3:    byte_sel = b3;
      default: byte_sel = b0 ^ b1 ^ b2 ^ b3;
    endcase
  end

  assign load      = !out_valid_q || pop_i;
  assign emit      = load && !cmd_empty_i;
  assign end_pkt   = (idx_q == POS_CHECKSUM);
  assign last_word = end_pkt && (next_rem == '0);
  assign cmd_pop_o = emit && last_word;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    idx_d  = idx_q;
    if (emit) begin
      if (end_pkt) begin
        idx_d  = '0;
        rem_d  = next_rem;
        busy_d = !last_word;
      end else begin
        idx_d  = idx_q + 3'd1;
        rem_d  = eff_mask;
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      idx_q  <= idx_d;
      if (load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tx_q   <= byte_sel;
      last_q <= last_word;
    end
  end

  assign empty_o     = !out_valid_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

  `XPDR_ASSERT_IMPL(a_busy_has_cmd, busy_q, !cmd_empty_i,
                    "back: descriptor left the queue before its last word")
  `XPDR_ASSERT(a_idx_range, idx_q <= POS_CHECKSUM, "back: byte index out of range")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for xor_packet_deframer_responder.
// Drives received words and register writes, predicts every response word.
// Depends on xpdr_pkg and the RTL of the block; nothing else.
module testbench import xpdr_pkg::*; ();

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned WATCHDOG_MAX  = 4000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PHASES        = 4;
  localparam int unsigned PKTS_PER_PHASE = 17;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  typedef enum logic {ROW_PACKET, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_SILENT} row_check_e;

  typedef struct packed {
    row_kind_e             kind;
    row_check_e            check;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           value;
    logic [39:0]           bytes;
    logic [39:0]           typed;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            rx_byte_i = 8'h00;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            tx_byte_o;
  logic                  last_byte_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Predictor state and its copy of the registers.
  logic [7:0]  frame_hold [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [2:0]  frame_pos = 3'd0;
  logic [15:0] saved_number = 16'h0000;
  logic        number_saved = 1'b0;
  logic [7:0]  reg_major = 8'h01;
  logic [7:0]  reg_minor = 8'h00;
  logic [15:0] reg_init_number = 16'h0000;

  tx_word_t tx_expected [$];
  tx_word_t answer_words [$];
  row_t     directed_rows [$];

  int unsigned fail_count = 0;
  int unsigned words_received = 0;
  int unsigned words_checked = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          feeding = 1'b0;
  bit          held_off = 1'b0;

  xor_packet_deframer_responder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .empty       (empty),
    .pop         (pop),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic row_t pkt_row(input logic [39:0] bytes, input row_check_e check,
                                   input logic [39:0] typed);
    row_t row;
    row = '0;
    row.kind = ROW_PACKET;
    row.check = check;
    row.bytes = bytes;
    row.typed = typed;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic add_packet(input logic [7:0] c, input logic [7:0] p1,
                            input logic [7:0] p2, input logic [7:0] p3);
    answer_words.push_back('{c, 1'b0});
    answer_words.push_back('{p1, 1'b0});
    answer_words.push_back('{p2, 1'b0});
    answer_words.push_back('{p3, 1'b0});
    answer_words.push_back('{c ^ p1 ^ p2 ^ p3, 1'b0});
  endtask

  // Builds the responses of the packet now held in frame_hold.
  task automatic answer_packet();
    logic [7:0]  c;
    logic        ok;
    logic [15:0] n;
    c = frame_hold[0];
    ok = 1'b0;
    n = number_saved ? saved_number : reg_init_number;
    case (c & ~ACK_BIT)
      CMD_STARTUP: begin
        add_packet(CMD_STARTUP, 8'h00, 8'h00, 8'h00);
        add_packet(CMD_VERSION, VERSION_TAG, reg_major, reg_minor);
        add_packet(CMD_NUMBER, SUB_GET, n[7:0], n[15:8]);
        ok = 1'b1;
      end
      CMD_VERSION: begin
        add_packet(CMD_VERSION, VERSION_TAG, reg_major, reg_minor);
        ok = 1'b1;
      end
      CMD_NUMBER: begin
        if (frame_hold[1] == SUB_GET) begin
          add_packet(CMD_NUMBER, SUB_GET, n[7:0], n[15:8]);
          ok = 1'b1;
        end else if (frame_hold[1] == SUB_SET) begin
          saved_number = {frame_hold[3], frame_hold[2]};
          number_saved = 1'b1;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    if ((c & ACK_BIT) != 8'h00) begin
      add_packet(ok ? (c | ACK_BIT) : (c & ~ACK_BIT), frame_hold[1], frame_hold[2],
                 frame_hold[3]);
    end
    if (answer_words.size() > 0) answer_words[answer_words.size() - 1].last = 1'b1;
  endtask

  // Advances the framing state by one received word.
  task automatic model_rx_word(input logic [7:0] b);
    answer_words.delete();
    if (frame_pos < POS_CHECKSUM) begin
      frame_hold[frame_pos[1:0]] = b;
      frame_pos = frame_pos + 3'd1;
    end else if (frame_pos == POS_CHECKSUM) begin
      if ((frame_hold[0] ^ frame_hold[1] ^ frame_hold[2] ^ frame_hold[3]) == b) begin
        frame_pos = 3'd0;
        answer_packet();
      end else begin
        // Bad checksum: slide the window and try again on the next word.
        frame_hold[0] = frame_hold[1];
        frame_hold[1] = frame_hold[2];
        frame_hold[2] = frame_hold[3];
        frame_hold[3] = b;
      end
    end else begin
      frame_pos = 3'd0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [7:0] b, input bit use_model);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    words_received++;
    model_rx_word(b);
    if (use_model) begin
      foreach (answer_words[k]) tx_expected.push_back(answer_words[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (tx_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_VERSION_MAJOR: reg_major = value[7:0];
      CFG_VERSION_MINOR: reg_minor = value[7:0];
      CFG_INITIAL_NUM:   reg_init_number = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_packet();
    logic [7:0]  c;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [7:0]  sum;
    int unsigned r;
    if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
    // A stray word now and then throws the framing off until the checksum resyncs.
    if ($urandom_range(0, 99) < 8) send_word(8'($urandom_range(0, 255)), 1'b1);
    r = $urandom_range(0, 99);
    if (r < 20) c = CMD_STARTUP;
    else if (r < 45) c = CMD_VERSION;
    else if (r < 80) c = CMD_NUMBER;
    else c = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) c = c | ACK_BIT;
    p1 = 8'($urandom_range(0, 255));
    p2 = 8'($urandom_range(0, 255));
    p3 = 8'($urandom_range(0, 255));
    if ((c & ~ACK_BIT) == CMD_NUMBER) begin
      r = $urandom_range(0, 9);
      if (r < 5) p1 = SUB_GET;
      else if (r < 9) p1 = SUB_SET;
    end
    sum = c ^ p1 ^ p2 ^ p3;
    if ($urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    send_word(c, 1'b1);
    send_word(p1, 1'b1);
    send_word(p2, 1'b1);
    send_word(p3, 1'b1);
    send_word(sum, 1'b1);
  endtask

  task automatic check_word(input logic [7:0] data, input logic last);
    tx_word_t want;
    words_checked++;
    if (tx_expected.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected word: got data %h last %b, none expected", data, last);
      end
    end else begin
      want = tx_expected.pop_front();
      if (want.data !== data || want.last !== last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("word mismatch: expected data %h last %b, got data %h last %b",
                   want.data, want.last, data, last);
        end
      end
    end
  endtask

  // Response side: random gaps, and one long hold-off while words keep arriving.
  initial begin : tx_drain
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held_off && feeding && words_checked >= 100) begin
        held_off = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = idle_len();
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_word(tx_byte_o, last_byte_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no word moved for %0d cycles, %0d words still expected",
                 idle_cycles, tx_expected.size());
        $display("xor_packet_deframer_responder regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] major_val;
    logic [15:0] minor_val;
    logic [15:0] number_val;
    // Directed part: reset values first, then the register extremes.
    directed_rows.push_back(pkt_row(40'h09_00_00_00_09, CHK_TYPED, 40'h09_76_01_00_7E));
    directed_rows.push_back(pkt_row(40'h0B_01_00_00_0A, CHK_TYPED, 40'h0B_01_00_00_0A));
    directed_rows.push_back(cfg_row(CFG_VERSION_MAJOR, 16'h00FF));
    directed_rows.push_back(cfg_row(CFG_VERSION_MINOR, 16'h00FF));
    directed_rows.push_back(cfg_row(CFG_INITIAL_NUM, 16'hFFFF));
    directed_rows.push_back(pkt_row(40'h84_00_00_00_84, CHK_MODEL, '0));
    directed_rows.push_back(pkt_row(40'h8B_02_00_00_89, CHK_TYPED, 40'h8B_02_00_00_89));
    // Unknown command with acknowledge: bit 7 comes back cleared.
    directed_rows.push_back(pkt_row(40'hFF_FF_FF_FF_00, CHK_TYPED, 40'h7F_FF_FF_FF_80));
    // Unknown sub-command without acknowledge gives no response.
    directed_rows.push_back(pkt_row(40'h0B_07_12_34_2A, CHK_SILENT, '0));
    // Checksum mismatch: the window slides instead of restarting.
    directed_rows.push_back(pkt_row(40'h00_00_00_00_01, CHK_MODEL, '0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    settings_used = 1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
        if (directed_rows[i].idx == CFG_INITIAL_NUM) settings_used++;
      end else begin
        for (int k = 0; k < 5; k++) begin
          send_word(directed_rows[i].bytes[39 - 8 * k -: 8],
                    directed_rows[i].check == CHK_MODEL);
        end
        if (directed_rows[i].check == CHK_TYPED) begin
          for (int k = 0; k < 5; k++) begin
            tx_expected.push_back('{directed_rows[i].typed[39 - 8 * k -: 8], k == 4});
          end
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          major_val = 16'h0000;
          minor_val = 16'h0000;
          number_val = 16'h0000;
        end
        1: begin
          major_val = 16'h00FF;
          minor_val = 16'h00FF;
          number_val = 16'hFFFF;
        end
        default: begin
          major_val = 16'($urandom_range(0, 65535));
          minor_val = 16'($urandom_range(0, 65535));
          number_val = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CFG_VERSION_MAJOR, major_val);
      write_reg(CFG_VERSION_MINOR, minor_val);
      write_reg(CFG_INITIAL_NUM, number_val);
      settings_used++;
      feeding = 1'b1;
      repeat (PKTS_PER_PHASE) send_random_packet();
      feeding = 1'b0;
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("sent %0d received words under %0d register settings, checked %0d responses",
             words_received, settings_used, words_checked);
    $display("long response hold-off done: %0b, failures: %0d", held_off, fail_count);
    if (fail_count == 0 && tx_expected.size() == 0) begin
      $display("xor_packet_deframer_responder regression: pass");
    end else begin
      $display("xor_packet_deframer_responder regression: fail");
    end
    $finish;
  end

endmodule
